@@ rtl/bce_pkg.sv @@
// ----------------------------------------------------------------------------
// bce_pkg
// Shared types and constants for the binary cross-entropy loss unit.
// ----------------------------------------------------------------------------
package bce_pkg;

   localparam int FRAC_BITS  = 24;
   localparam int IN_W       = 25;
   localparam int GRAD_W     = 49;
   localparam int LOSS_W     = 29;
   localparam int ACC_W      = 39;
   localparam int CFG_W      = 11;
   localparam int CNT_W      = 10;
   localparam int N_W        = 21;
   localparam int DVD_W      = 49;
   localparam int DVS_W      = 25;
   localparam int MAX_ROWS   = 1024;
   localparam int MAX_LEN    = 1024;

   localparam logic [IN_W-1:0]   ONE      = IN_W'(1) << FRAC_BITS;
   localparam logic [31:0]       LN2_Q32  = 32'hB17217F8;
   localparam logic [ACC_W-1:0]  ACC_MAX  = '1;
   localparam logic [GRAD_W-1:0] GRAD_POS = {1'b0, {(GRAD_W-1){1'b1}}};
   localparam logic [GRAD_W-1:0] GRAD_NEG = {1'b1, {(GRAD_W-1){1'b0}}};

   localparam logic [1:0] REG_ROW_LENGTH = 2'd0;
   localparam logic [1:0] REG_BATCH_ROWS = 2'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_T1,
      ST_DIV_T2,
      ST_DIV_N,
      ST_NORM,
      ST_SQ_MUL,
      ST_SQ_UPD,
      ST_LN_MUL,
      ST_LN_GET,
      ST_LN_ADD,
      ST_ACC,
      ST_DIV_L,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

endpackage

@@ rtl/bce_div.sv @@
// ----------------------------------------------------------------------------
// bce_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bce_div import bce_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  div_req_type      req,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [5:0]       cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;

   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (req.start) begin
         dvd_in = req.dividend;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[DVS_W]) begin
            rem_in = diff[DVS_W-1:0];
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DVD_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (req.start) begin
         dvs_ff <= req.divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

@@ rtl/binary_cross_entropy_loss_unit.sv @@
// ----------------------------------------------------------------------------
// binary_cross_entropy_loss_unit
// Per-element BCE gradient, hit flag and row-mean loss, one element at a time.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// req      in         req_valid/req_ready  req_prediction, req_target
// rsp      out        rsp_valid/rsp_ready  rsp_gradient, rsp_hit, rsp_row_done,
//                                          rsp_row_loss
// csr      in         csr_we               csr_index, csr_wdata
//
// From accept to the next accept, one element runs three 49-bit divisions on the
// bit-serial divider (four on a row's last element) and two log passes: normalize,
// 24 squarings each in a multiply and an update state, and scaling in the LN_MUL,
// LN_GET and LN_ADD states; then an accumulate state and a response state.
// Synchronous reset clears row state and sets both registers to 1.
// A result waiting on rsp_ready does not block the next request transaction.
// ----------------------------------------------------------------------------
module binary_cross_entropy_loss_unit import bce_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [IN_W-1:0]          req_prediction,
   input  logic [IN_W-1:0]          req_target,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [GRAD_W-1:0] rsp_gradient,
   output logic                     rsp_hit,
   output logic                     rsp_row_done,
   output logic [LOSS_W-1:0]        rsp_row_loss,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [CFG_W-1:0]         csr_wdata
);

   state_type state_ff, state_in;

   logic [CFG_W-1:0]  len_ff, rows_ff;
   logic [CFG_W-1:0]  len_eff, rows_eff;
   logic [N_W-1:0]    n_ff;
   logic [FRAC_BITS-1:0] pc_ff;
   logic [IN_W-1:0]   yc_ff;
   logic              hit_ff;
   logic              go_ff;
   logic [DVD_W-1:0]  t1_ff, mag_ff;
   logic              neg_ff;
   logic [GRAD_W-1:0] grad_ff;
   logic [31:0]       m_ff;
   logic [4:0]        k_ff;
   logic [FRAC_BITS-1:0] bits_ff;
   logic [4:0]        sq_cnt_ff;
   logic              sel_ff;
   logic [30:0]       e_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              done_ff;
   logic [LOSS_W-1:0] loss_ff;
   logic [63:0]       prod_ff;

   logic              rsp_valid_ff;
   logic [GRAD_W-1:0] rsp_grad_ff;
   logic              rsp_hit_ff, rsp_done_ff;
   logic [LOSS_W-1:0] rsp_loss_ff;

   div_req_type       div_req;
   logic              div_done;
   logic [DVD_W-1:0]  div_q;

   logic [FRAC_BITS-1:0] pc_in;
   logic [IN_W-1:0]   yc_in;
   logic [FRAC_BITS-1:0] pcomp;
   logic [IN_W-1:0]   ycomp;
   logic [31:0]       mul_a, mul_b;
   logic [32:0]       sq;
   logic [28:0]       nl2;
   logic [ACC_W:0]    acc_sum;
   logic              accept, rsp_free;

   bce_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_q)
   );

   assign len_eff  = (len_ff == '0) ? CFG_W'(1) :
                     (len_ff > CFG_W'(MAX_LEN)) ? CFG_W'(MAX_LEN) : len_ff;
   assign rows_eff = (rows_ff == '0) ? CFG_W'(1) :
                     (rows_ff > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_ff;

   assign pc_in = (req_prediction == '0) ? FRAC_BITS'(1) :
                  (req_prediction >= ONE) ? {FRAC_BITS{1'b1}} :
                  req_prediction[FRAC_BITS-1:0];
   assign yc_in = (req_target > ONE) ? ONE : req_target;
   assign pcomp = FRAC_BITS'(ONE - {1'b0, pc_ff});
   assign ycomp = ONE - yc_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign sq      = prod_ff[63:31];
   assign nl2     = {5'd24 - k_ff, {FRAC_BITS{1'b0}}} - {5'd0, bits_ff};
   assign acc_sum = {1'b0, acc_ff} + {9'd0, e_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_DIV_T1;
         ST_DIV_T1: if (go_ff && div_done) state_in = ST_DIV_T2;
         ST_DIV_T2: if (go_ff && div_done) state_in = ST_DIV_N;
         ST_DIV_N:  if (go_ff && div_done) state_in = ST_NORM;
         ST_NORM:   if (m_ff[31]) state_in = ST_SQ_MUL;
         ST_SQ_MUL: state_in = ST_SQ_UPD;
         ST_SQ_UPD: state_in = (sq_cnt_ff == 5'(FRAC_BITS - 1)) ? ST_LN_MUL : ST_SQ_MUL;
         ST_LN_MUL: state_in = ST_LN_GET;
         ST_LN_GET: state_in = ST_LN_ADD;
         ST_LN_ADD: state_in = sel_ff ? ST_ACC : ST_NORM;
         ST_ACC:    state_in = ({1'b0, cnt_ff} + 11'd1 >= len_eff) ? ST_DIV_L : ST_RESP;
         ST_DIV_L:  if (go_ff && div_done) state_in = ST_RESP;
         ST_RESP:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // divider request and multiplier operands
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      mul_a            = '0;
      mul_b            = '0;
      unique case (state_ff)
         ST_DIV_T1: begin
            div_req.start    = !go_ff;
            div_req.dividend = {yc_ff, {FRAC_BITS{1'b0}}};
            div_req.divisor  = {1'b0, pc_ff};
         end
         ST_DIV_T2: begin
            div_req.start    = !go_ff;
            div_req.dividend = {ycomp, {FRAC_BITS{1'b0}}};
            div_req.divisor  = {1'b0, pcomp};
         end
         ST_DIV_N: begin
            div_req.start    = !go_ff;
            div_req.dividend = mag_ff;
            div_req.divisor  = DVS_W'(n_ff);
         end
         ST_DIV_L: begin
            div_req.start    = !go_ff;
            div_req.dividend = DVD_W'(acc_ff);
            div_req.divisor  = DVS_W'(len_eff);
         end
         ST_SQ_MUL: begin
            mul_a = m_ff;
            mul_b = m_ff;
         end
         ST_LN_MUL: begin
            mul_a = {3'd0, nl2};
            mul_b = LN2_Q32;
         end
         ST_LN_GET: begin
            mul_a = {7'd0, sel_ff ? ycomp : yc_ff};
            mul_b = {3'd0, prod_ff[60:32]};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= CFG_W'(1);
         rows_ff      <= CFG_W'(1);
         acc_ff       <= '0;
         cnt_ff       <= '0;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_ROW_LENGTH: len_ff  <= csr_wdata;
               REG_BATCH_ROWS: rows_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (div_req.start) begin
            go_ff <= 1'b1;
         end else if (div_done) begin
            go_ff <= 1'b0;
         end
         if (state_ff == ST_ACC) begin
            acc_ff <= (acc_sum > {1'b0, ACC_MAX}) ? ACC_MAX : acc_sum[ACC_W-1:0];
            if ({1'b0, cnt_ff} + 11'd1 >= len_eff) begin
               cnt_ff <= '0;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         if (state_ff == ST_DIV_L && go_ff && div_done) begin
            acc_ff <= '0;
         end
         if (state_ff == ST_RESP && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      prod_ff <= mul_a * mul_b;

      if (accept) begin
         pc_ff  <= pc_in;
         yc_ff  <= yc_in;
         hit_ff <= (req_target == ((req_prediction >= (ONE >> 1)) ? ONE : '0));
         n_ff   <= {10'd0, rows_eff} * {10'd0, len_eff};
      end

      unique case (state_ff)
         ST_DIV_T1: if (go_ff && div_done) t1_ff <= div_q;
         ST_DIV_T2: if (go_ff && div_done) begin
            neg_ff <= t1_ff > div_q;
            mag_ff <= (t1_ff > div_q) ? t1_ff - div_q : div_q - t1_ff;
         end
         ST_DIV_N: if (go_ff && div_done) begin
            if (neg_ff) begin
               grad_ff <= (div_q > GRAD_NEG) ? GRAD_NEG : GRAD_W'(0) - div_q;
            end else begin
               grad_ff <= (div_q > GRAD_POS) ? GRAD_POS : div_q;
            end
            m_ff   <= {8'd0, pc_ff};
            k_ff   <= 5'd31;
            sel_ff <= 1'b0;
            e_ff   <= '0;
         end
         ST_NORM: begin
            bits_ff   <= '0;
            sq_cnt_ff <= '0;
            if (!m_ff[31]) begin
               m_ff <= {m_ff[30:0], 1'b0};
               k_ff <= k_ff - 5'd1;
            end
         end
         ST_SQ_UPD: begin
            // square is Q2.62; renormalize into [1,2) and emit one log2 bit
            m_ff      <= sq[32] ? sq[32:1] : sq[31:0];
            bits_ff   <= {bits_ff[FRAC_BITS-2:0], sq[32]};
            sq_cnt_ff <= sq_cnt_ff + 5'd1;
         end
         ST_LN_ADD: begin
            e_ff   <= e_ff + {1'b0, prod_ff[53:24]};
            sel_ff <= 1'b1;
            m_ff   <= {8'd0, pcomp};
            k_ff   <= 5'd31;
         end
         ST_ACC: loss_ff <= '0;
         ST_DIV_L: if (go_ff && div_done) begin
            loss_ff <= (div_q > DVD_W'({LOSS_W{1'b1}})) ? {LOSS_W{1'b1}}
                       : div_q[LOSS_W-1:0];
         end
         default: begin
         end
      endcase

      if (state_ff == ST_ACC) begin
         done_ff <= ({1'b0, cnt_ff} + 11'd1 >= len_eff);
      end

      if (state_ff == ST_RESP && rsp_free) begin
         rsp_grad_ff <= grad_ff;
         rsp_hit_ff  <= hit_ff;
         rsp_done_ff <= done_ff;
         rsp_loss_ff <= loss_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_gradient = rsp_grad_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_row_done = rsp_done_ff;
   assign rsp_row_loss = rsp_loss_ff;

endmodule
